// ===== rtl/sscl_pkg.sv =====
// Shared types and constants for the slave-serial configuration loader.
`default_nettype none

package sscl_pkg;

  // Command codes carried by each input transaction.
  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_DATA  = 2'd2,
    CMD_END   = 2'd3
  } cmd_t;

  // Status codes reported with each result transaction.
  typedef enum logic [2:0] {
    ST_BUSY       = 3'd0,
    ST_READY      = 3'd1,
    ST_SUCCESS    = 3'd2,
    ST_NO_INIT    = 3'd3,
    ST_TIMEOUT    = 3'd4,
    ST_DONE_EARLY = 3'd5,
    ST_CRC        = 3'd6
  } status_t;

  // Sequencer phases of the front end.
  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_PROG = 3'd1,
    PH_WAIT = 3'd2,
    PH_LOAD = 3'd3,
    PH_PAD  = 3'd4
  } phase_t;

  // Work handed from the front end to the pin driver.
  typedef struct packed {
    logic       shift;        // 1: shift a byte as 16 pin states, 0: one status result
    logic [7:0] byte_val;
    status_t    final_status;
    logic       prog_n;
  } job_t;

  localparam logic [7:0] INIT_TIMEOUT_RESET = 8'd100;
  localparam logic [7:0] PAD_BYTE           = 8'hff;
  localparam int         STEPS_PER_BYTE     = 16;

endpackage

`default_nettype wire

// ===== rtl/sscl_ifs.sv =====
// Channel interfaces for input items and result transactions.
`default_nettype none

interface sscl_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] data_byte;
  logic       init_low;
  logic       done_high;

  modport source (output valid, cmd, data_byte, init_low, done_high, input ready);
  modport sink (input valid, cmd, data_byte, init_low, done_high, output ready);
endinterface

interface sscl_out_if;
  logic       valid;
  logic       ready;
  logic       prog_n;
  logic       din;
  logic       cclk;
  logic [2:0] status;
  logic       last;

  modport source (output valid, prog_n, din, cclk, status, last, input ready);
  modport sink (input valid, prog_n, din, cclk, status, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/sscl_front.sv =====
// Front end: accepts items, runs the configuration phase sequencer, emits jobs.
`default_nettype none

module sscl_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [1:0]    cmd,
  input  wire logic [7:0]    data_byte,
  input  wire logic          init_low,
  input  wire logic          done_high,
  input  wire logic          cfg_we,
  input  wire logic [7:0]    cfg_wdata,
  input  wire logic          q_full,
  output logic               q_push,
  output sscl_pkg::job_t     q_job
);
  import sscl_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] wait_count_r, wait_count_nxt;
  logic       prog_r, prog_nxt;
  logic [7:0] init_timeout_r;
  logic       accept;
  cmd_t       cmd_c;
  logic [7:0] wc_inc;
  logic       timeout_hit;

  assign in_ready    = !q_full;
  assign accept      = in_valid && in_ready;
  assign cmd_c       = cmd_t'(cmd);
  assign wc_inc      = wait_count_r + 8'd1;
  assign timeout_hit = (wc_inc == 8'd0) || (wc_inc >= init_timeout_r);

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_timeout_r <= INIT_TIMEOUT_RESET;
    end else if (cfg_we) begin
      init_timeout_r <= cfg_wdata;
    end
  end

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      if (cmd_c == CMD_START) begin
        phase_nxt = PH_PROG;
      end else begin
        unique case (phase_r)
          PH_PROG: begin
            if (cmd_c == CMD_TICK) phase_nxt = init_low ? PH_WAIT : PH_IDLE;
          end
          PH_WAIT: begin
            if (cmd_c == CMD_TICK) begin
              if (!init_low) phase_nxt = done_high ? PH_IDLE : PH_LOAD;
              else if (timeout_hit) phase_nxt = PH_IDLE;
            end
          end
          PH_LOAD: begin
            if (cmd_c == CMD_DATA) begin
              if (init_low) phase_nxt = PH_IDLE;
            end else if (cmd_c == CMD_END) begin
              phase_nxt = (init_low || done_high) ? PH_IDLE : PH_PAD;
            end
          end
          PH_PAD: begin
            if (cmd_c == CMD_TICK && (init_low || done_high)) phase_nxt = PH_IDLE;
          end
          default: phase_nxt = phase_r;
        endcase
      end
    end
  end

  // Job generation and pin/counter updates.
  always_comb begin
    q_push         = 1'b0;
    q_job.shift    = 1'b0;
    q_job.byte_val = data_byte;
    q_job.final_status = ST_BUSY;
    prog_nxt       = prog_r;
    wait_count_nxt = wait_count_r;
    if (accept) begin
      if (cmd_c == CMD_START) begin
        prog_nxt       = 1'b0;
        wait_count_nxt = 8'd0;
        q_push         = 1'b1;
      end else begin
        unique case (phase_r)
          PH_PROG: begin
            if (cmd_c == CMD_TICK) begin
              prog_nxt       = 1'b1;
              q_push         = 1'b1;
              wait_count_nxt = 8'd0;
              q_job.final_status = init_low ? ST_BUSY : ST_NO_INIT;
            end
          end
          PH_WAIT: begin
            if (cmd_c == CMD_TICK) begin
              q_push = 1'b1;
              if (!init_low) begin
                q_job.final_status = done_high ? ST_DONE_EARLY : ST_READY;
              end else begin
                wait_count_nxt = wc_inc;
                q_job.final_status = timeout_hit ? ST_TIMEOUT : ST_BUSY;
              end
            end
          end
          PH_LOAD, PH_PAD: begin
            if (phase_r == PH_LOAD && cmd_c == CMD_DATA) begin
              q_push       = 1'b1;
              q_job.shift  = 1'b1;
              q_job.final_status = init_low ? ST_CRC : ST_READY;
            end else if ((phase_r == PH_LOAD && cmd_c == CMD_END)
                         || (phase_r == PH_PAD && cmd_c == CMD_TICK)) begin
              // Padding step: CRC error wins over DONE.
              q_push         = 1'b1;
              q_job.byte_val = PAD_BYTE;
              if (init_low) begin
                q_job.final_status = ST_CRC;
              end else begin
                q_job.shift = 1'b1;
                q_job.final_status = done_high ? ST_SUCCESS : ST_BUSY;
              end
            end
          end
          default: q_push = 1'b0;
        endcase
      end
    end
    q_job.prog_n = prog_nxt;
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      wait_count_r <= 8'd0;
      prog_r       <= 1'b1;
    end else begin
      phase_r      <= phase_nxt;
      wait_count_r <= wait_count_nxt;
      prog_r       <= prog_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sscl_fifo.sv =====
// Short job queue between the front end and the pin driver.
`default_nettype none

module sscl_fifo #(
  parameter int DEPTH = 2
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire sscl_pkg::job_t push_job,
  input  wire logic           pop,
  output sscl_pkg::job_t      head_job,
  output logic                full,
  output logic                empty
);
  import sscl_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_job = mem[rd_ptr_r];

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      if (do_push && !do_pop)      count_r <= count_r + CW'(1);
      else if (do_pop && !do_push) count_r <= count_r - CW'(1);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sscl_back.sv =====
// Pin driver: turns jobs into result transactions, one pin state per cycle unless the receiver stalls.
`default_nettype none

module sscl_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_empty,
  input  wire sscl_pkg::job_t q_job,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic                out_prog_n,
  output logic                out_din,
  output logic                out_cclk,
  output logic [2:0]          out_status,
  output logic                out_last
);
  import sscl_pkg::*;

  localparam logic [3:0] LAST_STEP = 4'(STEPS_PER_BYTE - 1);

  job_t       job_r;
  logic       active_r;
  logic [3:0] step_r;
  logic       din_r, cclk_r;
  logic       valid_r;
  logic       emit, finish;
  logic       din_c, cclk_c;
  logic [2:0] bit_idx;

  // A result is produced whenever a job is loaded and the output slot frees.
  assign emit    = active_r && (!valid_r || out_ready);
  assign finish  = emit && (!job_r.shift || step_r == LAST_STEP);
  assign q_pop   = !q_empty && (!active_r || finish);
  assign bit_idx = 3'd7 - step_r[3:1];
  assign din_c   = job_r.shift ? job_r.byte_val[bit_idx] : din_r;
  assign cclk_c  = job_r.shift ? step_r[0] : cclk_r;

  // Job and step control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      step_r   <= 4'd0;
      valid_r  <= 1'b0;
      din_r    <= 1'b0;
      cclk_r   <= 1'b0;
    end else begin
      if (q_pop) begin
        active_r <= 1'b1;
        step_r   <= 4'd0;
      end else if (finish) begin
        active_r <= 1'b0;
      end else if (emit) begin
        step_r <= step_r + 4'd1;
      end
      if (emit) begin
        valid_r <= 1'b1;
        din_r   <= din_c;
        cclk_r  <= cclk_c;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  // Job holding register.
  always_ff @(posedge clk) begin
    if (q_pop) job_r <= q_job;
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_prog_n <= job_r.prog_n;
      out_din    <= din_c;
      out_cclk   <= cclk_c;
      out_status <= finish ? job_r.final_status : ST_BUSY;
      out_last   <= finish;
    end
  end

  assign out_valid = valid_r;

endmodule

`default_nettype wire

// ===== rtl/fpga_slave_serial_config_loader_top.sv =====
// Top level of the slave-serial FPGA configuration loader.
//
// Input channel in_ch carries commands (start, time tick, data byte, end of
// data) together with the sampled INIT_B and DONE pins. The result channel
// out_ch carries pin states for PROG_B, DIN and CCLK plus a status code; the
// last result of an item has last set. cfg_we/cfg_wdata write init_timeout.
// The front end decodes each item in the cycle it is accepted and queues a
// job; the pin driver emits one result per cycle unless the receiver stalls.
// A data byte gives 16 results (DIN with CCLK low then high, MSB first), set
// by the pin driver's single step counter, as does a padding byte unless
// INIT_B is low. Other queued jobs give one result; ignored items give none.
// Items are taken while the job queue (QUEUE_DEPTH entries) has room, so a
// new item is accepted while earlier ones are still being shifted out.
// When the receiver stalls, the result register holds its transaction and
// the queue fills, after which in_ch.ready drops. Reset (rst_n low, sync)
// empties the queue, sets the phase to idle, the held PROG_B state released,
// held DIN and CCLK low and init_timeout to 100; out_ch payload is not reset.
`default_nettype none

module fpga_slave_serial_config_loader_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  sscl_in_if.sink         in_ch,
  sscl_out_if.source      out_ch,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata
);
  import sscl_pkg::*;

  job_t push_job, head_job;
  logic push, pop, full, empty;

  sscl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .cmd       (in_ch.cmd),
    .data_byte (in_ch.data_byte),
    .init_low  (in_ch.init_low),
    .done_high (in_ch.done_high),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (full),
    .q_push    (push),
    .q_job     (push_job)
  );

  sscl_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .full     (full),
    .empty    (empty)
  );

  sscl_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (empty),
    .q_job      (head_job),
    .q_pop      (pop),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_prog_n (out_ch.prog_n),
    .out_din    (out_ch.din),
    .out_cclk   (out_ch.cclk),
    .out_status (out_ch.status),
    .out_last   (out_ch.last)
  );

endmodule

`default_nettype wire
